// ===== src/measurement_frame_crc_decoder_macros.svh =====
// Assertion macros used by the measurement frame decoder top level.
`ifndef MEASUREMENT_FRAME_CRC_DECODER_MACROS_SVH
`define MEASUREMENT_FRAME_CRC_DECODER_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define MFCD_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition holds in the cycle after the trigger.
`define MFCD_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/mfcd_pkg.sv =====
// Types, constants and the CRC-8 step function of the measurement frame decoder.
package mfcd_pkg;

   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   localparam int unsigned TEMP_MUL = 175;
   localparam int unsigned HUM_MUL  = 100;
   localparam int signed   TEMP_OFFSET_Q8 = 11520;

   localparam logic STATUS_OK        = 1'b0;
   localparam logic STATUS_CRC_ERROR = 1'b1;

   // Which word of the frame is being received
   typedef enum logic [1:0] {
      WORD_CO2  = 2'd0,
      WORD_TEMP = 2'd1,
      WORD_HUM  = 2'd2
   } word_idx_type;

   // Which byte of the current word is expected next
   typedef enum logic [1:0] {
      PH_HIGH = 2'd0,
      PH_LOW  = 2'd1,
      PH_CRC  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_start;
   } item_type;

   typedef struct packed {
      logic               status;
      logic [15:0]        co2_ppm;
      logic signed [16:0] temperature_q8;
      logic [14:0]        humidity_q8;
   } result_type;

   typedef struct packed {
      logic         discarding;
      word_idx_type word_idx;
      phase_type    phase;
   } frame_status_type;

   // One byte through the CRC-8, MSB first, no final XOR
   function automatic logic [7:0] crc8_update(logic [7:0] crc, logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage

// ===== src/mfcd_scale.sv =====
// Fixed-point scaling of raw temperature and humidity words.
module mfcd_scale (
   input  logic [15:0]        raw_word,
   output logic signed [16:0] temperature_q8,
   output logic [14:0]        humidity_q8
);
   import mfcd_pkg::*;

   logic [23:0] temp_prod;
   logic [22:0] hum_prod;

   // Scale by the constant factors, drop the 8 fraction bits of the product
   assign temp_prod = {8'd0, raw_word} * 24'(TEMP_MUL);
   assign hum_prod  = {7'd0, raw_word} * 23'(HUM_MUL);

   // Apply the temperature offset in Q8
   assign temperature_q8 = $signed({1'b0, temp_prod[23:8]}) - 17'(TEMP_OFFSET_Q8);
   assign humidity_q8    = hum_prod[22:8];

endmodule

// ===== src/mfcd_frame.sv =====
// Frame position tracking, CRC check and word assembly, one byte per cycle in which fire is set.
module mfcd_frame (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       fire,
   input  mfcd_pkg::item_type         item,
   output logic                       emits,
   output mfcd_pkg::result_type       result,
   output mfcd_pkg::frame_status_type status
);
   import mfcd_pkg::*;

   word_idx_type word_ff, word_in, word_cur;
   phase_type    phase_ff, phase_in, phase_cur;
   logic [7:0]   crc_ff, crc_in, crc_cur;
   logic         disc_ff, disc_in, disc_cur;
   logic [7:0]   high_ff, high_in;
   logic [7:0]   low_ff, low_in;
   logic [15:0]  co2_ff, co2_in;
   logic signed [16:0] temp_ff, temp_in;
   logic         pos_ok;

   logic [15:0]        word_value;
   logic signed [16:0] temp_scaled;
   logic [14:0]        hum_scaled;

   assign word_value = {high_ff, low_ff};

   mfcd_scale u_scale (
      .raw_word       (word_value),
      .temperature_q8 (temp_scaled),
      .humidity_q8    (hum_scaled)
   );

   // Decode one byte against the current frame position
   always_comb begin
      // Frame start clears position, CRC and discard before the byte is used
      word_cur  = item.frame_start ? WORD_CO2 : word_ff;
      phase_cur = item.frame_start ? PH_HIGH  : phase_ff;
      crc_cur   = item.frame_start ? CRC_INIT : crc_ff;
      disc_cur  = item.frame_start ? 1'b0     : disc_ff;

      // Fall back to the first byte if the position is out of range
      pos_ok = (word_cur == WORD_CO2 || word_cur == WORD_TEMP || word_cur == WORD_HUM) &&
               (phase_cur == PH_HIGH || phase_cur == PH_LOW || phase_cur == PH_CRC);
      if (!pos_ok) begin
         word_cur  = WORD_CO2;
         phase_cur = PH_HIGH;
      end

      word_in  = word_cur;
      phase_in = phase_cur;
      crc_in   = crc_cur;
      disc_in  = disc_cur;
      high_in  = high_ff;
      low_in   = low_ff;
      co2_in   = co2_ff;
      temp_in  = temp_ff;
      emits    = 1'b0;
      result   = '0;

      if (!disc_cur) begin
         unique case (phase_cur)
            PH_HIGH: begin
               crc_in   = crc8_update(CRC_INIT, item.rx_byte);
               high_in  = item.rx_byte;
               phase_in = PH_LOW;
            end
            PH_LOW: begin
               crc_in   = crc8_update(crc_cur, item.rx_byte);
               low_in   = item.rx_byte;
               phase_in = PH_CRC;
            end
            PH_CRC: begin
               crc_in   = CRC_INIT;
               phase_in = PH_HIGH;
               if (crc_cur != item.rx_byte) begin
                  // Mismatch: report once, then drop bytes until a frame start
                  disc_in       = 1'b1;
                  word_in       = WORD_CO2;
                  emits         = 1'b1;
                  result.status = STATUS_CRC_ERROR;
               end else begin
                  unique case (word_cur)
                     WORD_CO2: begin
                        co2_in  = word_value;
                        word_in = WORD_TEMP;
                     end
                     WORD_TEMP: begin
                        temp_in = temp_scaled;
                        word_in = WORD_HUM;
                     end
                     WORD_HUM: begin
                        word_in               = WORD_CO2;
                        emits                 = 1'b1;
                        result.status         = STATUS_OK;
                        result.co2_ppm        = co2_ff;
                        result.temperature_q8 = temp_ff;
                        result.humidity_q8    = hum_scaled;
                     end
                     default: begin
                        word_in = WORD_CO2;
                     end
                  endcase
               end
            end
            default: begin
               phase_in = PH_HIGH;
            end
         endcase
      end
   end

   // Hold frame control state
   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= WORD_CO2;
         phase_ff <= PH_HIGH;
         crc_ff   <= CRC_INIT;
         disc_ff  <= 1'b0;
      end else if (fire) begin
         word_ff  <= word_in;
         phase_ff <= phase_in;
         crc_ff   <= crc_in;
         disc_ff  <= disc_in;
      end
   end

   // Hold partial words; always written before they are read
   always_ff @(posedge clock) begin
      if (fire) begin
         high_ff <= high_in;
         low_ff  <= low_in;
         co2_ff  <= co2_in;
         temp_ff <= temp_in;
      end
   end

   assign status.discarding = disc_ff;
   assign status.word_idx   = word_ff;
   assign status.phase      = phase_ff;

endmodule

// ===== src/measurement_frame_crc_decoder.sv =====
// Top level of the measurement frame decoder: input register, decoder, result register.
//
// Takes a 9-byte sensor response one byte per transfer (three words, each high
// byte, low byte, CRC-8 with polynomial 0x31 and seed 0xFF) and returns one
// result per complete frame: the CO2 word, temperature in degrees C and humidity
// in %RH, both truncated Q8 values, temperature in two's complement. The first
// CRC mismatch in a frame gives one result with status 1 and zero data, after
// which bytes are dropped until a byte with frame_start (req_tuser[0]) set. The
// block takes one byte every cycle unless stalled; a result passes through the
// input register and then the result register after its last byte is accepted.
// The only stall is a CRC byte that completes a result while the result
// register still holds an untaken transfer; that byte waits in the input register.
`include "measurement_frame_crc_decoder_macros.svh"

module measurement_frame_crc_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic [0:0]  req_tuser,   // [0] frame_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [15:0] co2_ppm, [32:16] temperature_q8, [47:33] humidity_q8
   output logic [0:0]  rsp_tuser    // [0] status
);
   import mfcd_pkg::*;

   logic             s1_valid_ff, s1_valid_in;
   item_type         s1_ff;
   logic             s1_fire;
   logic             emits;
   logic             out_free;
   result_type       result;
   frame_status_type fstat;
   logic             rsp_valid_ff, rsp_valid_in;
   result_type       rsp_ff;

   // Byte may proceed unless it makes a result and the result register is blocked
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && (!emits || out_free);
   assign req_tready = !s1_valid_ff || s1_fire;

   mfcd_frame u_frame (
      .clock  (clock),
      .reset  (reset),
      .fire   (s1_fire),
      .item   (s1_ff),
      .emits  (emits),
      .result (result),
      .status (fstat)
   );

   // Input register
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_ff.rx_byte     <= req_tdata;
         s1_ff.frame_start <= req_tuser[0];
      end
   end

   // Result register: load a new result, drop a taken one
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire && emits) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire && emits) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = {rsp_ff.humidity_q8, rsp_ff.temperature_q8, rsp_ff.co2_ppm};
   assign rsp_tuser[0] = rsp_ff.status;

   // Checks
   `MFCD_ASSERT_IMP(a_err_zero, clock, reset,
      rsp_tvalid && (rsp_tuser[0] == STATUS_CRC_ERROR), rsp_tdata == 48'd0,
      "error result carries nonzero data")
   `MFCD_ASSERT_IMP(a_disc_pos, clock, reset,
      fstat.discarding, (fstat.word_idx == WORD_CO2) && (fstat.phase == PH_HIGH),
      "discarding with frame position not at start")
   `MFCD_ASSERT_NXT(a_emit_load, clock, reset,
      s1_fire && emits, rsp_valid_ff,
      "emitted result not loaded into result register")
   `MFCD_ASSERT_NXT(a_s1_hold, clock, reset,
      s1_valid_ff && !s1_fire, s1_valid_ff && $stable(s1_ff),
      "stalled byte lost from input register")

endmodule

// ===== tb/measurement_frame_crc_decoder_tb.sv =====
// Self-checking testbench for the measurement frame CRC decoder.
`timescale 1ns / 100ps

module measurement_frame_crc_decoder_tb;

   import mfcd_pkg::*;

   localparam int CYCLE_LIMIT    = 400000;
   localparam int NO_BAD_WORD    = -1;
   localparam int RANDOM_BYTES   = 500;
   localparam int PRESSURE_AFTER = 150;
   localparam int PRESSURE_HOLD  = 400;

   // Frame predictor and store of expected frame results
   class frame_scoreboard;
      logic [3:0]  position;
      logic [7:0]  crc;
      logic [7:0]  high_byte;
      logic [7:0]  low_byte;
      logic [15:0] co2_word;
      logic [15:0] temp_word;
      bit          discarding;
      result_type  pending_frames[$];
      int          mismatches;
      int          used_bytes;

      function new();
         position   = '0;
         crc        = CRC_INIT;
         high_byte  = '0;
         low_byte   = '0;
         co2_word   = '0;
         temp_word  = '0;
         discarding = 1'b0;
         mismatches = 0;
         used_bytes = 0;
      endfunction

      // CRC-8, MSB first, shift one bit at a time
      static function logic [7:0] crc_next(logic [7:0] acc, logic [7:0] data);
         logic [7:0] c;
         c = acc ^ data;
         repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
         return c;
      endfunction

      function void flag_mismatch(string what);
         mismatches++;
         if (mismatches <= 10) $display("%0t ns: %s", $realtime, what);
      endfunction

      // Advance the predictor by one accepted byte
      function void note_byte(logic [7:0] data, logic start);
         result_type  frame;
         logic [15:0] word;
         int unsigned pos;
         int          temp_q8;
         if (start) begin
            position   = '0;
            crc        = CRC_INIT;
            discarding = 1'b0;
         end
         if (discarding) return;
         used_bytes++;
         pos = (position > 8) ? 0 : position;
         case (phase_type'(pos % 3))
            PH_HIGH: begin
               crc       = crc_next(CRC_INIT, data);
               high_byte = data;
               position  = 4'(pos + 1);
            end
            PH_LOW: begin
               crc      = crc_next(crc, data);
               low_byte = data;
               position = 4'(pos + 1);
            end
            default: begin
               if (crc != data) begin
                  // drop the rest of the frame, report the mismatch once
                  discarding   = 1'b1;
                  position     = '0;
                  crc          = CRC_INIT;
                  frame        = '0;
                  frame.status = STATUS_CRC_ERROR;
                  pending_frames.push_back(frame);
               end else begin
                  word = {high_byte, low_byte};
                  crc  = CRC_INIT;
                  case (word_idx_type'(pos / 3))
                     WORD_CO2: begin
                        co2_word = word;
                        position = 4'(pos + 1);
                     end
                     WORD_TEMP: begin
                        temp_word = word;
                        position  = 4'(pos + 1);
                     end
                     default: begin
                        // last word: scale and hand out the whole frame
                        temp_q8 = int'((32'(temp_word) * TEMP_MUL) >> 8) - TEMP_OFFSET_Q8;
                        frame.status         = STATUS_OK;
                        frame.co2_ppm        = co2_word;
                        frame.temperature_q8 = 17'(temp_q8);
                        frame.humidity_q8    = 15'((32'(word) * HUM_MUL) >> 8);
                        position             = '0;
                        pending_frames.push_back(frame);
                     end
                  endcase
               end
            end
         endcase
      endfunction

      // Compare one result transfer against the oldest expected frame
      function void check_frame(logic status, logic [47:0] data);
         result_type got;
         result_type want;
         got.status         = status;
         got.co2_ppm        = data[15:0];
         got.temperature_q8 = data[32:16];
         got.humidity_q8    = data[47:33];
         if (pending_frames.size() == 0) begin
            flag_mismatch($sformatf("unexpected result: status %0d co2 %0d temp %0d hum %0d",
               got.status, got.co2_ppm, got.temperature_q8, got.humidity_q8));
            return;
         end
         want = pending_frames.pop_front();
         if (got.status !== want.status || got.co2_ppm !== want.co2_ppm ||
             got.temperature_q8 !== want.temperature_q8 ||
             got.humidity_q8 !== want.humidity_q8)
            flag_mismatch($sformatf({"result mismatch: status exp %0d got %0d, co2 exp %0d ",
               "got %0d, temp exp %0d got %0d, hum exp %0d got %0d"},
               want.status, got.status, want.co2_ppm, got.co2_ppm,
               want.temperature_q8, got.temperature_q8, want.humidity_q8, got.humidity_q8));
      endfunction
   endclass

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [7:0] rx_byte
   logic [0:0]  req_tuser  = '0;   // [0] frame_start
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;         // [15:0] co2_ppm, [32:16] temperature_q8, [47:33] humidity_q8
   logic [0:0]  rsp_tuser;         // [0] status

   frame_scoreboard sb = new();
   bit              sender_calm = 1'b0;
   int              cycle_count = 0;

   measurement_frame_crc_decoder uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Mostly short gaps, now and then a long one
   function automatic int pick_gap(bit calm);
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 19);
      if (r < 12) return 0;
      if (r < 18) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Random data word, with the extremes mixed in
   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // Offer one byte and hold it until the transfer completes
   task automatic send_byte(input logic [7:0] data, input logic start);
      int gap;
      gap = pick_gap(sender_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= data;
      req_tuser[0] <= start;
      do @(posedge clock); while (!req_tready);
      sb.note_byte(data, start);
   endtask

   // Send the first count bytes of a frame, optionally with a corrupted CRC
   task automatic send_frame(input logic [15:0] co2, input logic [15:0] temp,
                             input logic [15:0] hum, input int bad_word,
                             input logic start, input int count);
      logic [15:0] words [3];
      logic [7:0]  frame_bytes [9];
      logic [7:0]  check;
      words = '{co2, temp, hum};
      for (int w = 0; w < 3; w++) begin
         check = frame_scoreboard::crc_next(
            frame_scoreboard::crc_next(CRC_INIT, words[w][15:8]), words[w][7:0]);
         if (w == bad_word) check ^= 8'($urandom_range(1, 255));
         frame_bytes[3*w]     = words[w][15:8];
         frame_bytes[3*w + 1] = words[w][7:0];
         frame_bytes[3*w + 2] = check;
      end
      for (int i = 0; i < count; i++) send_byte(frame_bytes[i], (i == 0) ? start : 1'b0);
   endtask

   // Check every completed result transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_frame(rsp_tuser[0], rsp_tdata);
   end

   // Stop a run that hangs
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("measurement_frame_crc_decoder_tb: FAIL");
         $finish;
      end
   end

   // Result side: random stalls, calm stretches and one long hold-off
   initial begin : receiver
      int  hold_cycles;
      int  calm_cycles;
      bit  pressure_done;
      hold_cycles   = 0;
      calm_cycles   = 0;
      pressure_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!pressure_done && sb.used_bytes >= PRESSURE_AFTER) begin
            hold_cycles   = PRESSURE_HOLD;
            pressure_done = 1'b1;
         end
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready <= 1'b1;
            if (calm_cycles > 0) calm_cycles--;
            else if ($urandom_range(0, 49) == 0) calm_cycles = $urandom_range(50, 200);
            else if ($urandom_range(0, 2) == 0) hold_cycles = pick_gap(1'b0);
         end
      end
   end

   initial begin : stimulus
      int choice;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // all-zero frame: lowest temperature, zero humidity
      send_frame(16'h0000, 16'h0000, 16'h0000, NO_BAD_WORD, 1'b1, 9);
      // all-ones frame taken without frame start right after a complete frame
      send_frame(16'hFFFF, 16'hFFFF, 16'hFFFF, NO_BAD_WORD, 1'b0, 9);
      // CRC mismatch in the first word, then a byte that must be dropped
      send_frame(pick_word(), pick_word(), pick_word(), 0, 1'b1, 3);
      send_byte(8'($urandom), 1'b0);
      // partial frame of four bytes, continued by whatever the random traffic below sends
      send_frame(pick_word(), pick_word(), pick_word(), NO_BAD_WORD, 1'b1, 4);

      // mostly good frames with random content, some broken ones and noise
      while (sb.used_bytes < RANDOM_BYTES) begin
         sender_calm = ($urandom_range(0, 5) == 0);
         choice      = $urandom_range(0, 19);
         if (choice < 13)
            send_frame(pick_word(), pick_word(), pick_word(), NO_BAD_WORD,
                       $urandom_range(0, 3) != 0, 9);
         else if (choice < 16)
            send_frame(pick_word(), pick_word(), pick_word(), $urandom_range(0, 2), 1'b1, 9);
         else if (choice < 18)
            send_frame(pick_word(), pick_word(), pick_word(), NO_BAD_WORD,
                       1'($urandom_range(0, 1)), $urandom_range(1, 8));
         else
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom), 1'($urandom_range(0, 1)));
      end
      req_tvalid <= 1'b0;

      // drain outstanding results, then allow for the pipeline latency
      while (sb.pending_frames.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_frames.size() == 0)
         $display("measurement_frame_crc_decoder_tb: PASS");
      else
         $display("measurement_frame_crc_decoder_tb: FAIL");
      $finish;
   end

endmodule
